// ===== rtl/rphdt_pkg.sv =====
`timescale 1ns / 1ps
package rphdt_pkg;

    localparam int COMP_W  = 21;
    localparam int PACK_W  = 63;
    localparam int DEPTH_W = 32;
    localparam int COLOR_W = 32;
    localparam int PIX_W   = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DOT_W   = 46;     // sum of three 21x22 products
    localparam int QUO_W   = 33;     // quotient bits kept; bit 32 flags overflow
    localparam int DIV_N_W = DOT_W + 10;
    localparam int PIXEL_COUNT_DEF = 1048576;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA   = 3'd0,
        REG_NORMAL   = 3'd1,
        REG_ORIGIN   = 3'd2,
        REG_COLOR    = 3'd3,
        REG_BOUND_EN = 3'd4,
        REG_RADIUS   = 3'd5,
        REG_NEAR     = 3'd6,
        REG_FAR      = 3'd7
    } t_cfg_reg;

    // Per-item sideband that rides along the pipeline.
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic               pix_ok;
        logic [DEPTH_W-1:0] depth;
        logic signed [COMP_W-1:0] dx;
        logic signed [COMP_W-1:0] dy;
        logic signed [COMP_W-1:0] dz;
    } t_side;

endpackage

// ===== rtl/rphdt_div_stage.sv =====
`timescale 1ns / 1ps
// One registered slice of the restoring divider: BITS quotient bits per stage.
module rphdt_div_stage #(
    parameter int BITS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rphdt_pkg::DIV_N_W-1:0]   i_rem,
    input  logic [rphdt_pkg::DIV_N_W-1:0]   i_num,
    input  logic [rphdt_pkg::DOT_W-1:0]     i_den,
    input  logic [rphdt_pkg::QUO_W-1:0]     i_quo,
    output logic [rphdt_pkg::DIV_N_W-1:0]   o_rem,
    output logic [rphdt_pkg::DIV_N_W-1:0]   o_num,
    output logic [rphdt_pkg::DOT_W-1:0]     o_den,
    output logic [rphdt_pkg::QUO_W-1:0]     o_quo
);
    import rphdt_pkg::*;

    logic [DIV_N_W-1:0] n_rem;
    logic [DIV_N_W-1:0] n_num;
    logic [QUO_W-1:0]   n_quo;

    always_comb begin
        logic [DIV_N_W:0] trial;
        n_rem = i_rem;
        n_num = i_num;
        n_quo = i_quo;
        for (int b = 0; b < BITS; b++) begin
            trial = {n_rem, n_num[DIV_N_W-1]};
            n_num = {n_num[DIV_N_W-2:0], 1'b0};
            if (trial >= {{(DIV_N_W-DOT_W+1){1'b0}}, i_den}) begin
                trial = trial - {{(DIV_N_W-DOT_W+1){1'b0}}, i_den};
                n_quo = {n_quo[QUO_W-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[QUO_W-2:0], 1'b0};
            end
            n_rem = trial[DIV_N_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_num <= n_num;
            o_den <= i_den;
            o_quo <= n_quo;
        end
    end
endmodule

// ===== rtl/ray_plane_hit_depth_test.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is free or being taken, so a stall freezes every stage in place.
// The depth of the pipe is set by the quotient: 56 dividend bits, 4 per stage.
// Reset (synchronous, active low) clears all valid bits and loads the register
// defaults: everything zero except the far limit, which is all ones.
module ray_plane_hit_depth_test #(
    parameter int PIXEL_COUNT = rphdt_pkg::PIXEL_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [rphdt_pkg::PIX_W-1:0]         i_pixel_index,
    input  logic signed [rphdt_pkg::COMP_W-1:0] i_dir_x,
    input  logic signed [rphdt_pkg::COMP_W-1:0] i_dir_y,
    input  logic signed [rphdt_pkg::COMP_W-1:0] i_dir_z,
    input  logic [rphdt_pkg::DEPTH_W-1:0]       i_depth_in,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rphdt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rphdt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [rphdt_pkg::PIX_W-1:0]         o_pixel_out,
    output logic                                o_hit,
    output logic [rphdt_pkg::DEPTH_W-1:0]       o_depth_out,
    output logic [rphdt_pkg::COLOR_W-1:0]       o_color_out
);
    import rphdt_pkg::*;

    localparam int DIV_BITS = 4;
    localparam int DIV_ST   = DIV_N_W / DIV_BITS;   // 14 divider stages
    localparam int PRE_ST   = 3;                    // diff, products, dot sums
    localparam int POST_ST  = 6;                    // range, step mul, offset, square, sums, out
    localparam int SIDE_N   = PRE_ST + DIV_ST + POST_ST;
    localparam logic [24:0] PIX_LIM = 25'(PIXEL_COUNT);

    // ---------------- configuration registers ----------------
    logic [PACK_W-1:0]  r_cam, r_nrm, r_org;
    logic [COLOR_W-1:0] r_color;
    logic               r_ben;
    logic [DEPTH_W-1:0] r_rad, r_near, r_far;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam <= '0; r_nrm <= '0; r_org <= '0; r_color <= '0;
            r_ben <= 1'b0; r_rad <= '0; r_near <= '0; r_far <= '1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_CAMERA:   r_cam   <= i_cfg_data[PACK_W-1:0];
                REG_NORMAL:   r_nrm   <= i_cfg_data[PACK_W-1:0];
                REG_ORIGIN:   r_org   <= i_cfg_data[PACK_W-1:0];
                REG_COLOR:    r_color <= i_cfg_data[COLOR_W-1:0];
                REG_BOUND_EN: r_ben   <= i_cfg_data[0];
                REG_RADIUS:   r_rad   <= i_cfg_data[DEPTH_W-1:0];
                REG_NEAR:     r_near  <= i_cfg_data[DEPTH_W-1:0];
                REG_FAR:      r_far   <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [COMP_W-1:0] lane(input logic [PACK_W-1:0] p, input int k);
        lane = p[k*COMP_W +: COMP_W];
    endfunction

    // ---------------- pipeline control ----------------
    // The output register is the only place that can hold a beat against a
    // stall, so the pipe moves as one whenever it is empty or being drained.
    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    logic [SIDE_N-1:0] r_v;
    t_side             r_side [SIDE_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[SIDE_N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0].pix    <= i_pixel_index;
            r_side[0].pix_ok <= {5'd0, i_pixel_index} < PIX_LIM;
            r_side[0].depth  <= i_depth_in;
            r_side[0].dx     <= i_dir_x;
            r_side[0].dy     <= i_dir_y;
            r_side[0].dz     <= i_dir_z;
            for (int s = 1; s < SIDE_N; s++) r_side[s] <= r_side[s-1];
        end
    end

    // ---------------- stage 1: plane offset (config only, stays constant) -----
    logic signed [COMP_W:0]   r_diff [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++)
                r_diff[k] <= (COMP_W+1)'(lane(r_org, k)) - (COMP_W+1)'(lane(r_cam, k));
        end
    end

    // ---------------- stage 2: six products ----------------
    logic signed [2*COMP_W:0]   r_pn [3];
    logic signed [2*COMP_W-1:0] r_pd [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) r_pn[k] <= lane(r_nrm, k) * r_diff[k];
            r_pd[0] <= lane(r_nrm, 0) * r_side[0].dx;
            r_pd[1] <= lane(r_nrm, 1) * r_side[0].dy;
            r_pd[2] <= lane(r_nrm, 2) * r_side[0].dz;
        end
    end

    // ---------------- stage 3: dot sums, signs and magnitudes ----------------
    logic [DOT_W-1:0] r_num_mag, r_den_mag;
    logic             r_sign_bad, r_den_zero;
    always_ff @(posedge i_clk) begin
        logic signed [DOT_W-1:0] num, den;
        if (adv) begin
            num = DOT_W'(r_pn[0]) + DOT_W'(r_pn[1]) + DOT_W'(r_pn[2]);
            den = DOT_W'(r_pd[0]) + DOT_W'(r_pd[1]) + DOT_W'(r_pd[2]);
            r_num_mag  <= num[DOT_W-1] ? DOT_W'(-num) : DOT_W'(num);
            r_den_mag  <= den[DOT_W-1] ? DOT_W'(-den) : DOT_W'(den);
            r_den_zero <= den == '0;
            r_sign_bad <= (num != '0) && (num[DOT_W-1] != den[DOT_W-1]);
        end
    end

    // ---------------- divider: 14 stages of 4 quotient bits ----------------
    logic [DIV_N_W-1:0] w_rem [DIV_ST+1];
    logic [DIV_N_W-1:0] w_num [DIV_ST+1];
    logic [DOT_W-1:0]   w_den [DIV_ST+1];
    logic [QUO_W-1:0]   w_quo [DIV_ST+1];
    logic [1:0]         r_flag [DIV_ST];

    assign w_rem[0] = '0;
    assign w_num[0] = {r_num_mag, 10'd0};
    assign w_den[0] = r_den_mag;
    assign w_quo[0] = '0;

    // A quotient wider than 32 bits only has to be flagged: the overflow bit
    // is made sticky by watching bits shifted out of the quotient register.
    logic r_ovf [DIV_ST];

    for (genvar g = 0; g < DIV_ST; g++) begin : g_div
        rphdt_div_stage #(.BITS(DIV_BITS)) u_stage (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_rem (w_rem[g]),
            .i_num (w_num[g]),
            .i_den (w_den[g]),
            .i_quo (w_quo[g]),
            .o_rem (w_rem[g+1]),
            .o_num (w_num[g+1]),
            .o_den (w_den[g+1]),
            .o_quo (w_quo[g+1])
        );
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_flag[g] <= {r_den_zero, r_sign_bad};
                    r_ovf[g]  <= 1'b0;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_flag[g] <= r_flag[g-1];
                    r_ovf[g]  <= r_ovf[g-1] || (w_quo[g][QUO_W-1 -: DIV_BITS] != '0);
                end
            end
        end
    end

    // ---------------- post 1: range checks ----------------
    localparam int SQ = PRE_ST + DIV_ST;   // sideband index after the divider
    logic [DEPTH_W-1:0] r_t1;
    logic               r_ok1;
    always_ff @(posedge i_clk) begin
        logic ovf;
        if (adv) begin
            ovf   = r_ovf[DIV_ST-1] || w_quo[DIV_ST][QUO_W-1];
            r_t1  <= w_quo[DIV_ST][DEPTH_W-1:0];
            r_ok1 <= !ovf && !r_flag[DIV_ST-1][1] && !r_flag[DIV_ST-1][0]
                     && r_side[SQ-1].pix_ok
                     && (w_quo[DIV_ST][DEPTH_W-1:0] >= r_near)
                     && (w_quo[DIV_ST][DEPTH_W-1:0] <= r_side[SQ-1].depth)
                     && (w_quo[DIV_ST][DEPTH_W-1:0] <  r_far);
        end
    end

    // ---------------- post 2: t * |dir| ----------------
    logic [DEPTH_W-1:0] r_t2, r_t3, r_t4, r_t5;
    logic               r_ok2, r_ok3, r_ok4, r_ok5;
    logic [DEPTH_W+COMP_W-1:0] r_stp [3];
    logic                      r_neg [3];
    always_ff @(posedge i_clk) begin
        logic signed [COMP_W-1:0] d [3];
        logic [COMP_W-1:0] m;
        if (adv) begin
            d[0] = r_side[SQ].dx; d[1] = r_side[SQ].dy; d[2] = r_side[SQ].dz;
            for (int k = 0; k < 3; k++) begin
                m = d[k][COMP_W-1] ? COMP_W'(-d[k]) : COMP_W'(d[k]);
                r_stp[k] <= r_t1 * m;
                r_neg[k] <= d[k][COMP_W-1];
            end
            r_t2 <= r_t1; r_ok2 <= r_ok1;
        end
    end

    // ---------------- post 3: offset from the plane origin ----------------
    logic [DEPTH_W+COMP_W:0] r_ad [3];
    always_ff @(posedge i_clk) begin
        logic signed [DEPTH_W+COMP_W+1:0] s, p;
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                s = (DEPTH_W+COMP_W+2)'(r_stp[k] >> 10);
                if (r_neg[k]) s = -s;
                p = s + (DEPTH_W+COMP_W+2)'(lane(r_cam, k)) - (DEPTH_W+COMP_W+2)'(lane(r_org, k));
                r_ad[k] <= p[DEPTH_W+COMP_W+1] ? (DEPTH_W+COMP_W+1)'(-p)
                                               : (DEPTH_W+COMP_W+1)'(p);
            end
            r_t3 <= r_t2; r_ok3 <= r_ok2;
        end
    end

    // ---------------- post 4: squares (each component at most the radius) ----------
    logic [2*DEPTH_W-1:0] r_sq [3];
    logic                 r_in4;
    always_ff @(posedge i_clk) begin
        logic in;
        if (adv) begin
            in = 1'b1;
            for (int k = 0; k < 3; k++) begin
                if (r_ad[k] > (DEPTH_W+COMP_W+1)'(r_rad)) in = 1'b0;
                r_sq[k] <= r_ad[k][DEPTH_W-1:0] * r_ad[k][DEPTH_W-1:0];
            end
            r_in4 <= in;
            r_t4 <= r_t3; r_ok4 <= r_ok3;
        end
    end

    // ---------------- post 5: sum of squares against radius squared ---------
    logic [2*DEPTH_W-1:0] r_rad_sq;
    logic                 r_in5;
    always_ff @(posedge i_clk) begin
        logic [2*DEPTH_W+1:0] sum;
        if (adv) begin
            r_rad_sq <= r_rad * r_rad;
            sum = (2*DEPTH_W+2)'(r_sq[0]) + (2*DEPTH_W+2)'(r_sq[1]) + (2*DEPTH_W+2)'(r_sq[2]);
            // Sums beyond 64 bits count as outside the disc.
            r_in5 <= r_in4 && (sum[2*DEPTH_W+1:2*DEPTH_W] == 2'b00)
                     && (sum[2*DEPTH_W-1:0] <= r_rad_sq);
            r_t5 <= r_t4; r_ok5 <= r_ok4;
        end
    end

    // ---------------- output register ----------------
    logic hit;
    assign hit = r_ok5 && (!r_ben || r_in5);
    assign o_valid = r_v[SIDE_N-1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_pixel_out <= r_side[SIDE_N-2].pix;
            o_hit       <= hit;
            o_depth_out <= hit ? r_t5 : r_side[SIDE_N-2].depth;
            o_color_out <= hit ? r_color : '0;
        end
    end

    // ---------------- assertions ----------------
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_depth_out))
        else $error("output beat changed under stall");
    a_miss_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_color_out == '0)
        else $error("color on a miss");
    a_hit_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_depth_out != '1)
        else $error("hit at the all-ones far limit");

endmodule

// ===== tb/rphdt_checker.sv =====
`timescale 1ns / 1ps
// Watches the ray, register and result channels of the plane hit block.
// It predicts each result when a ray beat is taken and compares it in order
// with the result beats that leave the block.
module rphdt_checker
    import rphdt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_in_stall,
    input  logic [PIX_W-1:0]         i_pixel_index,
    input  logic [COMP_W-1:0]        i_dir_x,
    input  logic [COMP_W-1:0]        i_dir_y,
    input  logic [COMP_W-1:0]        i_dir_z,
    input  logic [DEPTH_W-1:0]       i_depth_in,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [PIX_W-1:0]         i_pixel_out,
    input  logic                     i_hit,
    input  logic [DEPTH_W-1:0]       i_depth_out,
    input  logic [COLOR_W-1:0]       i_color_out,
    output int                       o_pending,
    output int                       o_failures
);

    typedef struct {
        logic [PIX_W-1:0]   pix;
        logic               hit;
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] color;
    } t_pixel_update;

    logic [PACK_W-1:0]  camera;
    logic [PACK_W-1:0]  normal;
    logic [PACK_W-1:0]  origin;
    logic [COLOR_W-1:0] color;
    logic               bound_en;
    logic [31:0]        radius;
    logic [31:0]        near_lim;
    logic [31:0]        far_lim;

    t_pixel_update pixel_updates_q[$];

    function automatic longint lane(logic [PACK_W-1:0] packed_v, int k);
        logic signed [COMP_W-1:0] c;
        c = packed_v[COMP_W*k +: COMP_W];
        return longint'(c);
    endfunction

    function automatic logic [63:0] mag(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Distance to the plane along the ray; returns 1 when the ray lands.
    function automatic logic find_hit(longint dir[3], logic [31:0] depth,
                                      output logic [63:0] t);
        longint num, den, s, p;
        logic [63:0] step, ad, sq, sum;
        num = 0;
        den = 0;
        t = 0;
        for (int k = 0; k < 3; k++) begin
            num += lane(normal, k) * (lane(origin, k) - lane(camera, k));
            den += lane(normal, k) * dir[k];
        end
        if (den == 0) return 1'b0;
        if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
        t = (mag(num) << 10) / mag(den);
        if (t > 64'hFFFF_FFFF || t < {32'd0, near_lim}) return 1'b0;
        if (t > {32'd0, depth} || t >= {32'd0, far_lim}) return 1'b0;
        if (bound_en) begin
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                step = (t * mag(dir[k])) >> 10;
                s = (dir[k] < 0) ? -longint'(step) : longint'(step);
                p = lane(camera, k) + s;
                ad = mag(p - lane(origin, k));
                if (ad > {32'd0, radius}) return 1'b0;
                sq = ad * ad;
                if (sum + sq < sum) return 1'b0;
                sum += sq;
            end
            if (sum > {32'd0, radius} * {32'd0, radius}) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_pixel_update trace_ray(logic [PIX_W-1:0] pix,
        logic [COMP_W-1:0] dx, logic [COMP_W-1:0] dy, logic [COMP_W-1:0] dz,
        logic [DEPTH_W-1:0] depth);
        t_pixel_update u;
        longint dir[3];
        logic [63:0] t;
        logic landed;
        dir[0] = longint'(signed'(dx));
        dir[1] = longint'(signed'(dy));
        dir[2] = longint'(signed'(dz));
        landed = find_hit(dir, depth, t);
        u.pix   = pix;
        u.hit   = landed;
        u.depth = landed ? t[31:0] : depth;
        u.color = landed ? color : '0;
        return u;
    endfunction

    task automatic report(string field, logic [PIX_W-1:0] pix,
                          logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch on %s for pixel %0d: got %0h, expected %0h",
                 $realtime, field, pix, got, want);
        o_failures++;
    endtask

    initial begin
        o_pending  = 0;
        o_failures = 0;
    end

    always @(posedge i_clk) begin
        t_pixel_update want;
        if (!i_rst_n) begin
            camera   <= '0;
            normal   <= '0;
            origin   <= '0;
            color    <= '0;
            bound_en <= 1'b0;
            radius   <= '0;
            near_lim <= '0;
            far_lim  <= '1;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_CAMERA:   camera   <= i_cfg_data[PACK_W-1:0];
                    REG_NORMAL:   normal   <= i_cfg_data[PACK_W-1:0];
                    REG_ORIGIN:   origin   <= i_cfg_data[PACK_W-1:0];
                    REG_COLOR:    color    <= i_cfg_data[COLOR_W-1:0];
                    REG_BOUND_EN: bound_en <= i_cfg_data[0];
                    REG_RADIUS:   radius   <= i_cfg_data[31:0];
                    REG_NEAR:     near_lim <= i_cfg_data[31:0];
                    REG_FAR:      far_lim  <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall)
                pixel_updates_q.push_back(trace_ray(i_pixel_index, i_dir_x, i_dir_y,
                                                    i_dir_z, i_depth_in));
            if (i_out_valid && !i_out_stall) begin
                if (pixel_updates_q.size() == 0) begin
                    $display("%0t result beat for pixel %0d with none expected",
                             $realtime, i_pixel_out);
                    o_failures++;
                end else begin
                    want = pixel_updates_q.pop_front();
                    if (i_pixel_out !== want.pix)
                        report("pixel", want.pix, i_pixel_out, want.pix);
                    if (i_hit !== want.hit)
                        report("hit", want.pix, i_hit, want.hit);
                    if (i_depth_out !== want.depth)
                        report("depth", want.pix, i_depth_out, want.depth);
                    if (i_color_out !== want.color)
                        report("color", want.pix, i_color_out, want.color);
                end
            end
            o_pending = pixel_updates_q.size();
        end
    end

endmodule

// ===== tb/tb_ray_plane_hit_depth_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the ray-plane hit block. The checker beside the
// block predicts and compares every result beat; this module only drives the
// channels, applies back pressure and decides pass or fail at the end.
module tb_ray_plane_hit_depth_test;
    import rphdt_pkg::*;

    localparam int DRAIN_CYCLES = 40;      // comfortably above the pipeline latency
    localparam int WATCHDOG_LIMIT = 4000;  // idle cycles allowed with no beat at all
    localparam int HOLD_CYCLES = 80;       // long receiver hold-off, fills the pipe

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_pixel_index;
    logic [COMP_W-1:0]     i_dir_x;
    logic [COMP_W-1:0]     i_dir_y;
    logic [COMP_W-1:0]     i_dir_z;
    logic [DEPTH_W-1:0]    i_depth_in;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid;
    logic                  i_stall;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_hit;
    logic [DEPTH_W-1:0]    o_depth_out;
    logic [COLOR_W-1:0]    o_color_out;

    int pending;
    int failures;
    int idle_cycles = 0;

    // Controls shared between the ray sender and the result receiver.
    bit quiet;      // no idling on either side
    bit hold_req;   // receiver should hold off for a long stretch

    ray_plane_hit_depth_test u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_index (i_pixel_index),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .i_depth_in    (i_depth_in),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_out   (o_pixel_out),
        .o_hit         (o_hit),
        .o_depth_out   (o_depth_out),
        .o_color_out   (o_color_out)
    );

    rphdt_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_in_stall    (o_stall),
        .i_pixel_index (i_pixel_index),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .i_depth_in    (i_depth_in),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_pixel_out   (o_pixel_out),
        .i_hit         (o_hit),
        .i_depth_out   (o_depth_out),
        .i_color_out   (o_color_out),
        .o_pending     (pending),
        .o_failures    (failures)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // The watchdog restarts whenever any channel moves a beat. A stall that
    // never clears, or a result that never comes, ends the run here.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Pack three Q11.10 components into the 63-bit vector layout, x lowest.
    function automatic logic [CFG_DATA_W-1:0] pack3(int x, int y, int z);
        logic [COMP_W-1:0] cx, cy, cz;
        cx = COMP_W'(x);
        cy = COMP_W'(y);
        cz = COMP_W'(z);
        return {1'b0, cz, cy, cx};
    endfunction

    // Register writes happen only with the pipe empty. The ray channel is
    // closed first; every ray yields a result, so once nothing is pending the
    // block is idle, and the extra cycles are margin on top of that.
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [CFG_DATA_W-1:0] cam, logic [CFG_DATA_W-1:0] nrm,
                             logic [CFG_DATA_W-1:0] org, logic [31:0] col, logic bnd,
                             logic [31:0] rad, logic [31:0] nr, logic [31:0] fr);
        write_reg(REG_CAMERA, cam);
        write_reg(REG_NORMAL, nrm);
        write_reg(REG_ORIGIN, org);
        write_reg(REG_COLOR, {32'd0, col});
        write_reg(REG_BOUND_EN, {63'd0, bnd});
        write_reg(REG_RADIUS, {32'd0, rad});
        write_reg(REG_NEAR, {32'd0, nr});
        write_reg(REG_FAR, {32'd0, fr});
    endtask

    // Offers one ray beat and returns at the falling edge after it is taken.
    // The valid stays high so that back-to-back beats need no second write.
    task automatic send_ray(int dx, int dy, int dz, logic [31:0] depth);
        i_valid       <= 1'b1;
        i_pixel_index <= PIX_W'($urandom);
        i_dir_x       <= COMP_W'(dx);
        i_dir_y       <= COMP_W'(dy);
        i_dir_z       <= COMP_W'(dz);
        i_depth_in    <= depth;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    // Random ray: mostly moderate directions that land on the plane at
    // sensible distances, some tiny ones that push t out of range, and some
    // with every bit random.
    task automatic random_ray();
        int dx, dy, dz;
        logic [31:0] depth;
        case ($urandom_range(0, 9))
            0, 1: begin
                dx = $urandom_range(0, 16) - 8;
                dy = $urandom_range(0, 16) - 8;
                dz = $urandom_range(0, 16) - 8;
            end
            2, 3: begin
                dx = int'($urandom);
                dy = int'($urandom);
                dz = int'($urandom);
            end
            default: begin
                dx = $urandom_range(0, 4096) - 2048;
                dy = $urandom_range(0, 4096) - 2048;
                dz = $urandom_range(0, 4096) - 2048;
            end
        endcase
        depth = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 1 << 21);
        send_ray(dx, dy, dz, depth);
        sender_gap();
    endtask

    task automatic random_phase(int count, int hold_at, int drain_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_req = 1'b1;
            if (n == drain_at) begin
                i_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
                @(negedge i_clk);
            end
            random_ray();
        end
    endtask

    // Result receiver: random stall bursts, one long hold-off on request.
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        quiet         = 1'b0;
        hold_req      = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pixel_index = '0;
        i_dir_x       = '0;
        i_dir_y       = '0;
        i_dir_z       = '0;
        i_depth_in    = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_CAMERA;
        i_cfg_data    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: a zero normal gives a zero denominator for every ray.
        send_ray(1024, -1024, 1024, 32'hFFFF_FFFF);
        send_ray(0, 0, 0, 32'd0);

        // Flat plane at z = 10.0 seen from the origin, no bound, full range.
        write_all(pack3(0, 0, 0), pack3(0, 0, 1024), pack3(0, 0, 10240),
                  32'hA5C3_0F81, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_ray(0, 0, 1024, 32'hFFFF_FFFF);       // straight hit at t = 10.0
        send_ray(0, 0, 0, 32'hFFFF_FFFF);          // zero direction, no denominator
        send_ray(0, 0, -1024, 32'hFFFF_FFFF);      // plane is behind the camera
        send_ray(0, 0, 1024, 32'd10239);           // depth just nearer than t
        send_ray(0, 0, 1024, 32'd10240);           // depth equal to t still hits
        send_ray(-1048576, 1048575, 1, 32'hFFFF_FFFF);
        send_ray(1048575, -1048576, -1048576, 32'hFFFF_FFFF);
        send_ray(0, 0, 1048575, 32'd0);

        // Near and far limits and the disc bound of radius 5.0.
        write_all(pack3(0, 0, 0), pack3(0, 0, 1024), pack3(0, 0, 10240),
                  32'h0000_FFFF, 1'b1, 32'd5120, 32'd1024, 32'd102400);
        send_ray(0, 0, 20000, 32'hFFFF_FFFF);      // t below the near limit
        send_ray(0, 0, 100, 32'hFFFF_FFFF);        // t beyond the far limit
        send_ray(1024, 0, 1024, 32'hFFFF_FFFF);    // lands outside the disc
        send_ray(256, 0, 1024, 32'hFFFF_FFFF);     // lands inside the disc
        send_ray(0, -500, 1024, 32'hFFFF_FFFF);
        send_ray(3620, 3620, 1024, 32'hFFFF_FFFF); // lands far outside the disc
        random_phase(90, 40, -1);

        // Extreme geometry: steep normal and far-apart points overflow t.
        // Bit 63 of the vector writes must be dropped by the block.
        write_all(pack3(-1048576, 0, 0) | 64'h8000_0000_0000_0000, pack3(1048575, 0, 1),
                  pack3(1048575, 0, 0), 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF,
                  32'd0, 32'hFFFF_FFFF);
        send_ray(0, 0, 1, 32'hFFFF_FFFF);          // t overflows the depth range
        send_ray(1, 0, 0, 32'hFFFF_FFFF);
        send_ray(0, 1048575, 0, 32'hFFFF_FFFF);
        random_phase(60, -1, 30);

        // Everything at the extremes: near limit all ones, far limit zero.
        write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        random_phase(40, -1, -1);

        // Tilted plane, offset camera, random disc.
        write_all(pack3(2048, -1024, 512), pack3(724, 0, 724), pack3(0, 3072, 20480),
                  $urandom, 1'b1, $urandom_range(1024, 40960), $urandom_range(0, 2048),
                  $urandom_range(65536, 1 << 24));
        random_phase(90, -1, -1);

        // Random geometry with moderate components, bound off.
        write_all(pack3($urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
                        $urandom_range(0, 8192) - 4096),
                  pack3($urandom_range(0, 2048) - 1024, $urandom_range(0, 2048) - 1024,
                        $urandom_range(0, 2048) - 1024),
                  pack3($urandom_range(0, 65536) - 32768, $urandom_range(0, 65536) - 32768,
                        $urandom_range(0, 65536) - 32768),
                  $urandom, 1'b0, $urandom, 32'd0, 32'hFFFF_FFFF);
        random_phase(90, -1, -1);

        // Final stretch at full rate on both sides.
        quiet = 1'b1;
        random_phase(80, -1, -1);
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
